// ----- rtl/ictf_pkg.sv -----
package ictf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CordicN = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int CNT_W = $clog2(CordicN + 1);

  localparam int CW = 40;
  localparam int ZW = 34;
  localparam int AW = 18;

  localparam int ACC_W = 24;
  localparam int INC_W = 18;
  localparam int RATE_W = 17;

  localparam logic [16:0] INC_DIV = 17'd62500;
  localparam logic [17:0] INC_BIAS_Q = 18'd68720;
  localparam logic [33:0] INC_NUM_OFS = 34'd4295031250;

  localparam logic signed [ZW-1:0] HALF_TURN = 34'sd3019898880;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 34'sd754974720;
      5'd1:  v = 34'sd445687602;
      5'd2:  v = 34'sd235489089;
      5'd3:  v = 34'sd119537938;
      5'd4:  v = 34'sd60000934;
      5'd5:  v = 34'sd30029717;
      5'd6:  v = 34'sd15018523;
      5'd7:  v = 34'sd7509720;
      5'd8:  v = 34'sd3754917;
      5'd9:  v = 34'sd1877466;
      5'd10: v = 34'sd938734;
      5'd11: v = 34'sd469367;
      5'd12: v = 34'sd234684;
      5'd13: v = 34'sd117342;
      5'd14: v = 34'sd58671;
      5'd15: v = 34'sd29335;
      5'd16: v = 34'sd14668;
      5'd17: v = 34'sd7334;
      5'd18: v = 34'sd3667;
      5'd19: v = 34'sd1833;
      5'd20: v = 34'sd917;
      5'd21: v = 34'sd458;
      5'd22: v = 34'sd229;
      5'd23: v = 34'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/imu_complementary_tilt_filter.sv -----
// Complementary tilt filter, one IMU sample per word. The time a sample takes from
// acceptance to result is set by the five bit-serial increment lanes (a shift-add multiply
// followed by a restoring divide by 62500); the shared CORDIC (16 steps for roll, then 16
// for pitch) and the blend multiply run alongside or after them. One sample is worked on
// at a time; a new one is taken while the previous result waits at the output. Angles are
// in 1/256 degree.
module imu_complementary_tilt_filter import ictf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, interval_us
  input  logic [111:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tilt_roll, tilt_pitch, raw_roll, raw_pitch, raw_yaw, fixed_roll, fixed_pitch,
  // fused_roll, fused_pitch
  output logic [207:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [1:0] REG_ROLL_OFS  = 2'd0;
  localparam logic [1:0] REG_PITCH_OFS = 2'd1;
  localparam logic [1:0] REG_GYRO_W    = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_ROLL  = 6'b000100,
    S_PITCH = 6'b001000,
    S_BLEND = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;

  logic signed [15:0] roll_rate_offset;
  logic signed [15:0] pitch_rate_offset;
  logic [8:0]         gyro_weight;
  logic [8:0]         w_eff;

  logic signed [15:0] accel_x, accel_y, accel_z;
  logic signed [15:0] rate_x, rate_y, rate_z;
  logic [15:0]        interval_us;

  logic signed [AW-1:0]    troll;
  logic signed [AW-1:0]    pitch_hold;
  logic signed [16:0]      out_troll;
  logic signed [15:0]      out_tpitch;

  logic signed [ACC_W-1:0] raw_roll, raw_pitch, raw_yaw;
  logic signed [ACC_W-1:0] fixed_roll, fixed_pitch;
  logic signed [ACC_W-1:0] fused_roll, fused_pitch;

  logic               sq_busy;
  logic [15:0]        mag;
  logic               cd_start, cd_busy;
  logic signed [16:0] cd_y, cd_x;
  logic signed [AW-1:0] cd_angle;
  logic signed [AW-1:0] roll_clamped, pitch_clamped;
  logic               inc_start;
  logic [4:0]         inc_busy;
  logic signed [INC_W-1:0] inc_rr, inc_rp, inc_ry, inc_cr, inc_cp;
  logic               bl_start;
  logic               bl_busy_r, bl_busy_p;
  logic signed [ACC_W-1:0] bl_roll, bl_pitch;
  logic               out_load;
  logic               cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign w_eff  = (gyro_weight > 9'd256) ? 9'd256 : gyro_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_rate_offset  <= '0;
      pitch_rate_offset <= '0;
      gyro_weight       <= 9'd230;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROLL_OFS:  roll_rate_offset  <= pwdata[15:0];
        REG_PITCH_OFS: pitch_rate_offset <= pwdata[15:0];
        REG_GYRO_W:    gyro_weight       <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROLL_OFS:  prdata = {{16{roll_rate_offset[15]}}, roll_rate_offset};
      REG_PITCH_OFS: prdata = {{16{pitch_rate_offset[15]}}, pitch_rate_offset};
      REG_GYRO_W:    prdata = {23'b0, gyro_weight};
      default:       prdata = '0;
    endcase
  end

  // sequencer
  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);
  assign inc_start = (state == S_START);
  assign cd_start = (state == S_START) || ((state == S_ROLL) && !cd_busy && !sq_busy);
  assign cd_y = (state == S_START) ? 17'(accel_y) : -17'(accel_x);
  assign cd_x = (state == S_START) ? 17'(accel_z) : {1'b0, mag};
  assign bl_start = (state == S_PITCH) && !cd_busy && (inc_busy == '0);

  always_comb begin
    if (cd_angle > 18'sd46080) begin
      roll_clamped = 18'sd46080;
    end else if (cd_angle < -18'sd46080) begin
      roll_clamped = -18'sd46080;
    end else begin
      roll_clamped = cd_angle;
    end
    if (cd_angle > 18'sd23040) begin
      pitch_clamped = 18'sd23040;
    end else if (cd_angle < -18'sd23040) begin
      pitch_clamped = -18'sd23040;
    end else begin
      pitch_clamped = cd_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (s_tvalid) state <= S_START;
        S_START: state <= S_ROLL;
        S_ROLL:  if (cd_start) state <= S_PITCH;
        S_PITCH: if (bl_start) state <= S_BLEND;
        S_BLEND: if (!bl_busy_r && !bl_busy_p) state <= S_OUT;
        S_OUT:   if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      accel_x     <= s_tdata[15:0];
      accel_y     <= s_tdata[31:16];
      accel_z     <= s_tdata[47:32];
      rate_x      <= s_tdata[63:48];
      rate_y      <= s_tdata[79:64];
      rate_z      <= s_tdata[95:80];
      interval_us <= s_tdata[111:96];
    end
    if (state == S_ROLL && cd_start) begin
      troll <= roll_clamped;
    end
    if (out_load) begin
      out_troll  <= troll[16:0];
      out_tpitch <= pitch_hold[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (bl_start) begin
      pitch_hold <= pitch_clamped;
    end
  end

  // state update and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      raw_roll    <= '0;
      raw_pitch   <= '0;
      raw_yaw     <= '0;
      fixed_roll  <= '0;
      fixed_pitch <= '0;
      fused_roll  <= '0;
      fused_pitch <= '0;
    end else if (out_load) begin
      m_tvalid    <= 1'b1;
      raw_roll    <= raw_roll + ACC_W'(inc_rr);
      raw_pitch   <= raw_pitch + ACC_W'(inc_rp);
      raw_yaw     <= raw_yaw + ACC_W'(inc_ry);
      fixed_roll  <= fixed_roll + ACC_W'(inc_cr);
      fixed_pitch <= fixed_pitch + ACC_W'(inc_cp);
      fused_roll  <= bl_roll;
      fused_pitch <= bl_pitch;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {7'b0, fused_pitch, fused_roll, fixed_pitch, fixed_roll,
                    raw_yaw, raw_pitch, raw_roll, out_tpitch, out_troll};

  ictf_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (inc_start),
    .a     (accel_y),
    .b     (accel_z),
    .busy  (sq_busy),
    .root  (mag)
  );

  ictf_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cd_start),
    .y_in  (cd_y),
    .x_in  (cd_x),
    .busy  (cd_busy),
    .angle (cd_angle)
  );

  ictf_incr u_inc_rr (
    .clk (clk), .rst (rst), .start (inc_start),
    .rate (RATE_W'(rate_x)), .t (interval_us), .busy (inc_busy[0]), .inc (inc_rr)
  );

  ictf_incr u_inc_rp (
    .clk (clk), .rst (rst), .start (inc_start),
    .rate (RATE_W'(rate_y)), .t (interval_us), .busy (inc_busy[1]), .inc (inc_rp)
  );

  ictf_incr u_inc_ry (
    .clk (clk), .rst (rst), .start (inc_start),
    .rate (RATE_W'(rate_z)), .t (interval_us), .busy (inc_busy[2]), .inc (inc_ry)
  );

  ictf_incr u_inc_cr (
    .clk (clk), .rst (rst), .start (inc_start),
    .rate (RATE_W'(rate_x) - RATE_W'(roll_rate_offset)),
    .t (interval_us), .busy (inc_busy[3]), .inc (inc_cr)
  );

  ictf_incr u_inc_cp (
    .clk (clk), .rst (rst), .start (inc_start),
    .rate (RATE_W'(rate_y) - RATE_W'(pitch_rate_offset)),
    .t (interval_us), .busy (inc_busy[4]), .inc (inc_cp)
  );

  ictf_blend u_blend_r (
    .clk (clk), .rst (rst), .start (bl_start),
    .acc (fused_roll), .cinc (inc_cr), .tilt (troll), .w (w_eff),
    .busy (bl_busy_r), .fused (bl_roll)
  );

  ictf_blend u_blend_p (
    .clk (clk), .rst (rst), .start (bl_start),
    .acc (fused_pitch), .cinc (inc_cp), .tilt (pitch_clamped), .w (w_eff),
    .busy (bl_busy_p), .fused (bl_pitch)
  );

`ifndef SYNTHESIS
  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!cd_busy && !bl_busy_r && !bl_busy_p && inc_busy == '0))
    else $error("unit busy while idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_START))
    else $error("accepted word not started");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_troll <= 17'sd46080 && out_troll >= -17'sd46080))
    else $error("tilt roll out of range");
`endif

endmodule

// ----- rtl/ictf_isqrt.sv -----
module ictf_isqrt import ictf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic               busy,
  output logic [15:0]        root
);

  logic [31:0] rem;
  logic [31:0] r;
  logic [31:0] bitv;
  logic [32:0] trial;
  logic signed [31:0] sq_a;
  logic signed [31:0] sq_b;

  assign sq_a = a * a;
  assign sq_b = b * b;
  assign trial = {1'b0, r} + {1'b0, bitv};
  assign root = r[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bitv == 32'd1) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= 32'(sq_a) + 32'(sq_b);
      r    <= '0;
      bitv <= 32'h4000_0000;
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[31:0];
        r   <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ----- rtl/ictf_cordic.sv -----
module ictf_cordic import ictf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [16:0]   y_in,
  input  logic signed [16:0]   x_in,
  output logic                 busy,
  output logic signed [AW-1:0] angle
);

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic [CNT_W-1:0]     cnt;
  logic                 zero;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] zr;

  assign xs = {{(CW-37){x_in[16]}}, x_in, 20'b0};
  assign ys = {{(CW-37){y_in[16]}}, y_in, 20'b0};
  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign zr = z + ZW'(32768);
  assign angle = zero ? '0 : zr[ZW-1:ZW-AW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(CordicN - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      zero <= (x_in == '0) && (y_in == '0);
      if (x_in[16]) begin
        x <= -xs;
        y <= -ys;
        z <= y_in[16] ? -HALF_TURN : HALF_TURN;
      end else begin
        x <= xs;
        y <= ys;
        z <= '0;
      end
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (!y[CW-1]) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_entry(5'(cnt));
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_entry(5'(cnt));
      end
    end
  end

endmodule

// ----- rtl/ictf_incr.sv -----
module ictf_incr import ictf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [RATE_W-1:0] rate,
  input  logic [15:0]             t,
  output logic                    busy,
  output logic signed [INC_W-1:0] inc
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_LOAD = 4'b0100,
    L_DIV  = 4'b1000
  } lane_state_t;

  lane_state_t state;
  logic [5:0]          cnt;
  logic signed [RATE_W-1:0] rt;
  logic [15:0]         tsh;
  logic signed [32:0]  prod;
  logic [33:0]         nq;
  logic [15:0]         rem;
  logic [17:0]         trial;

  assign busy  = (state != L_IDLE);
  assign trial = {1'b0, rem, nq[33]} - {1'b0, INC_DIV};
  assign inc   = INC_W'(nq[17:0] - INC_BIAS_Q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (start) begin
            state <= L_MUL;
            cnt   <= '0;
          end
        end
        L_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == 6'd15) begin
            state <= L_LOAD;
          end
        end
        L_LOAD: begin
          state <= L_DIV;
          cnt   <= '0;
        end
        L_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == 6'd33) begin
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        if (start) begin
          rt   <= rate;
          tsh  <= t;
          prod <= '0;
        end
      end
      L_MUL: begin
        prod <= (prod <<< 1) + (tsh[15] ? 33'(rt) : 33'sd0);
        tsh  <= tsh << 1;
      end
      L_LOAD: begin
        nq  <= {prod[32], prod} + INC_NUM_OFS;
        rem <= '0;
      end
      L_DIV: begin
        if (!trial[17]) begin
          rem <= trial[15:0];
          nq  <= {nq[32:0], 1'b1};
        end else begin
          rem <= {rem[14:0], nq[33]};
          nq  <= {nq[32:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/ictf_blend.sv -----
module ictf_blend import ictf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] acc,
  input  logic signed [INC_W-1:0] cinc,
  input  logic signed [AW-1:0]    tilt,
  input  logic [8:0]              w,
  output logic                    busy,
  output logic signed [ACC_W-1:0] fused
);

  logic signed [25:0]   d;
  logic signed [AW-1:0] tb;
  logic [8:0]           wsh;
  logic signed [34:0]   p;
  logic [3:0]           cnt;
  logic signed [35:0]   s;
  logic signed [27:0]   q;

  assign s = 36'(p) + {{10{tb[AW-1]}}, tb, 8'b0} + 36'sd128;
  assign q = s[35:8];

  always_comb begin
    if (q > 28'sd8388607) begin
      fused = 24'h7FFFFF;
    end else if (q < -28'sd8388608) begin
      fused = 24'h800000;
    end else begin
      fused = q[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 4'd8) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d   <= 26'(acc) + 26'(cinc) - 26'(tilt);
      tb  <= tilt;
      wsh <= w;
      p   <= '0;
      cnt <= '0;
    end else if (busy) begin
      p   <= (p <<< 1) + (wsh[8] ? 35'(d) : 35'sd0);
      wsh <= wsh << 1;
      cnt <= cnt + 1'b1;
    end
  end

endmodule
